[sv/vrq_pkg.sv]
`default_nettype none

package vrq_pkg;

    localparam int unsigned CAPACITY     = 4096;
    localparam int unsigned HEADER_SIZE  = 8;
    localparam int unsigned START_OFFSET = 16;
    localparam int unsigned TYPE_BITS    = 8;

    localparam int unsigned ADDR_W = $clog2(CAPACITY);
    localparam int unsigned LEN_W  = 13;
    localparam int unsigned CNT_W  = 13;

    localparam logic [LEN_W-1:0] START_OFF = LEN_W'(START_OFFSET);
    localparam logic [LEN_W-1:0] HDR_LEN   = LEN_W'(HEADER_SIZE);
    localparam logic [LEN_W-1:0] CAP_LEN   = LEN_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_PEEK = 2'd1,
        OP_POP  = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_BAD_LEN = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    typedef struct packed {
        logic                 pad;
        logic [TYPE_BITS-1:0] typ;
        logic [LEN_W-1:0]     len;
    } t_hdr;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_hdr              data;
    } t_mem_wr;

    typedef struct packed {
        t_status              status;
        logic [ADDR_W-1:0]    offset;
        logic [LEN_W-1:0]     len;
        logic [TYPE_BITS-1:0] typ;
        logic [CNT_W-1:0]     count;
    } t_result;

    typedef struct packed {
        logic    done;
        logic    wrap;
        logic    rd;
        logic    wr_pad;
        logic    wr_rec;
        t_status status;
    } t_act;

endpackage

`default_nettype wire

[sv/vrq_req_if.sv]
`default_nettype none

interface vrq_req_if;
    import vrq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [LEN_W-1:0]     record_length;
    logic [7:0]           record_type;

    modport source (output valid, output operation, output record_length,
                    output record_type, input ready);
    modport sink   (input valid, input operation, input record_length,
                    input record_type, output ready);
endinterface

`default_nettype wire

[sv/vrq_rsp_if.sv]
`default_nettype none

interface vrq_rsp_if;
    import vrq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [ADDR_W-1:0]    offset;
    logic [LEN_W-1:0]     length_out;
    logic [7:0]           type_out;
    logic [CNT_W-1:0]     record_count;

    modport source (output valid, output status, output offset, output length_out,
                    output type_out, output record_count, input ready);
    modport sink   (input valid, input status, input offset, input length_out,
                    input type_out, input record_count, output ready);
endinterface

`default_nettype wire

[sv/vrq_hdr_mem.sv]
`default_nettype none

module vrq_hdr_mem (
    input  wire logic                      i_clk,
    input  wire vrq_pkg::t_mem_wr          i_wr,
    input  wire logic                      i_rd_en,
    input  wire logic [vrq_pkg::ADDR_W-1:0] i_rd_addr,
    output vrq_pkg::t_hdr                  o_rd_data
);
    import vrq_pkg::*;

    t_hdr r_mem [CAPACITY];
    t_hdr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

[sv/vrq_ctrl.sv]
`default_nettype none

module vrq_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    vrq_req_if.sink                         i_req,
    input  wire logic [vrq_pkg::LEN_W-1:0]  i_region_size,
    input  wire logic                       i_slot_free,
    input  wire vrq_pkg::t_hdr              i_rd_data,
    output vrq_pkg::t_mem_wr                o_wr,
    output logic                            o_rd_en,
    output logic [vrq_pkg::ADDR_W-1:0]      o_rd_addr,
    output logic                            o_done,
    output vrq_pkg::t_result                o_result
);
    import vrq_pkg::*;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [TYPE_BITS-1:0] r_typ, n_typ;
    logic [LEN_W-1:0]     r_wo, n_wo;
    logic [LEN_W-1:0]     r_ro, n_ro;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_wrapped, n_wrapped;
    logic                 r_chk_pad, n_chk_pad;

    logic [LEN_W-1:0]     w_size;
    logic [LEN_W:0]       w_wo_len, w_wo_hdr, w_ro_hdr, w_ro_len;
    logic                 w_accept;
    t_act                 w_act;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_size   = (i_region_size > CAP_LEN) ? CAP_LEN : i_region_size;
    assign w_wo_len = {1'b0, r_wo} + {1'b0, r_len};
    assign w_wo_hdr = {1'b0, r_wo} + {1'b0, HDR_LEN};
    assign w_ro_hdr = {1'b0, r_ro} + {1'b0, HDR_LEN};
    assign w_ro_len = {1'b0, r_ro} + {1'b0, i_rd_data.len};

    // one step of the push / find-oldest walk
    always_comb begin
        w_act        = '0;
        w_act.status = ST_OK;
        case (r_state)
            S_EXEC: begin
                if (i_slot_free) begin
                    case (r_op)
                        OP_PUSH: begin
                            if (r_len < HDR_LEN) begin
                                w_act.done   = 1'b1;
                                w_act.status = ST_BAD_LEN;
                            end else if (r_wo >= r_ro) begin
                                if (w_wo_len >= {1'b0, w_size}) begin
                                    w_act.wr_pad = (w_wo_hdr <= {1'b0, w_size});
                                    if (r_ro == START_OFF || r_wrapped) begin
                                        w_act.done   = 1'b1;
                                        w_act.status = ST_FULL;
                                    end else begin
                                        w_act.wrap = 1'b1;
                                    end
                                end else begin
                                    w_act.wr_rec = 1'b1;
                                    w_act.done   = 1'b1;
                                end
                            end else if (w_wo_len >= {1'b0, r_ro}) begin
                                w_act.done   = 1'b1;
                                w_act.status = ST_FULL;
                            end else begin
                                w_act.wr_rec = 1'b1;
                                w_act.done   = 1'b1;
                            end
                        end
                        OP_PEEK, OP_POP: begin
                            if (r_wo > r_ro) begin
                                if ({1'b0, r_wo} >= w_ro_hdr) begin
                                    w_act.rd = 1'b1;
                                end else begin
                                    w_act.done   = 1'b1;
                                    w_act.status = ST_EMPTY;
                                end
                            end else if (r_wo == r_ro) begin
                                w_act.done   = 1'b1;
                                w_act.status = ST_EMPTY;
                            end else if (w_ro_hdr <= {1'b0, w_size}) begin
                                w_act.rd = 1'b1;
                            end else if (r_wrapped) begin
                                w_act.done   = 1'b1;
                                w_act.status = ST_EMPTY;
                            end else begin
                                w_act.wrap = 1'b1;
                            end
                        end
                        default: begin
                            w_act.done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (i_slot_free) begin
                    if (r_chk_pad && i_rd_data.pad) begin
                        if (r_wrapped) begin
                            w_act.done   = 1'b1;
                            w_act.status = ST_EMPTY;
                        end else begin
                            w_act.wrap = 1'b1;
                        end
                    end else begin
                        w_act.done = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_act.done) begin
                    n_state = S_IDLE;
                end else if (w_act.rd) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_act.done) begin
                    n_state = S_IDLE;
                end else if (w_act.wrap) begin
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_len     = r_len;
        n_typ     = r_typ;
        n_wo      = r_wo;
        n_ro      = r_ro;
        n_cnt     = r_cnt;
        n_wrapped = r_wrapped;
        n_chk_pad = r_chk_pad;

        if (w_accept) begin
            n_op      = t_op'(i_req.operation);
            n_len     = i_req.record_length;
            n_typ     = i_req.record_type[TYPE_BITS-1:0];
            n_wrapped = 1'b0;
        end

        if (w_act.wrap) begin
            n_wrapped = 1'b1;
            if (r_op == OP_PUSH) begin
                n_wo = START_OFF;
            end else begin
                n_ro = START_OFF;
            end
        end

        if (w_act.rd) begin
            n_chk_pad = (r_wo <= r_ro);
        end

        if (w_act.wr_rec) begin
            n_wo = w_wo_len[LEN_W-1:0];
            if (r_cnt != CNT_MAX) begin
                n_cnt = r_cnt + 1'b1;
            end
        end

        if (r_state == S_READ && w_act.done && w_act.status == ST_OK && r_op == OP_POP) begin
            n_ro = (w_ro_len > {1'b0, CAP_LEN}) ? CAP_LEN : w_ro_len[LEN_W-1:0];
            if (r_cnt != '0) begin
                n_cnt = r_cnt - 1'b1;
            end
        end

        o_wr.en   = w_act.wr_pad || w_act.wr_rec;
        o_wr.addr = r_wo[ADDR_W-1:0];
        if (w_act.wr_pad) begin
            o_wr.data.pad = 1'b1;
            o_wr.data.typ = '0;
            o_wr.data.len = w_size - r_wo;
        end else begin
            o_wr.data.pad = 1'b0;
            o_wr.data.typ = r_typ;
            o_wr.data.len = r_len;
        end

        o_rd_en   = w_act.rd;
        o_rd_addr = r_ro[ADDR_W-1:0];

        o_done          = w_act.done;
        o_result        = '0;
        o_result.status = w_act.status;
        o_result.count  = n_cnt;
        if (w_act.status == ST_OK) begin
            if (w_act.wr_rec) begin
                o_result.offset = r_wo[ADDR_W-1:0];
            end else if (r_state == S_READ) begin
                o_result.offset = r_ro[ADDR_W-1:0];
                o_result.len    = i_rd_data.len;
                o_result.typ    = i_rd_data.typ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wo      <= START_OFF;
            r_ro      <= START_OFF;
            r_cnt     <= '0;
            r_wrapped <= 1'b0;
            r_chk_pad <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wo      <= n_wo;
            r_ro      <= n_ro;
            r_cnt     <= n_cnt;
            r_wrapped <= n_wrapped;
            r_chk_pad <= n_chk_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_len <= n_len;
        r_typ <= n_typ;
    end

endmodule

`default_nettype wire

[sv/variable_record_ring_queue_core.sv]
// Variable-length record ring queue: header bookkeeping for a byte ring.
// Request channel i_req carries operation (push, peek, pop), record_length
// and record_type; response channel o_rsp returns status, offset,
// length_out, type_out and record_count, one response per transaction.
// i_cfg_wr_en / i_cfg_wr_data write the region size; write it only while
// no transaction is in flight.
// Headers live in a 4096-entry single-port-write, one-read memory with a
// registered read. One transaction is worked on at a time:
//   push:      evaluate and write, with a wrap to the start offset first if needed
//   peek/pop:  evaluate, header read, decide; pad headers or a short tail
//              force a wrap to the start offset first
// The result is registered when the transaction finishes.
// A new request is taken while a response still waits; if the receiver
// stalls, the next transaction holds at its current step until the output
// register frees up.
// Reset (synchronous, active low) empties the queue, sets both offsets to
// the start offset and the region size to 4096; header memory is not
// cleared since no header is read before it is written.
`default_nettype none

module variable_record_ring_queue_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [vrq_pkg::LEN_W-1:0] i_cfg_wr_data,
    vrq_req_if.sink                        i_req,
    vrq_rsp_if.source                      o_rsp
);
    import vrq_pkg::*;

    logic [LEN_W-1:0]  r_region_size;
    t_result           r_rsp;
    logic              r_rsp_valid;

    logic              w_slot_free;
    logic              w_done;
    t_result           w_result;
    t_mem_wr           w_wr;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    t_hdr              w_rd_data;

    assign w_slot_free = !r_rsp_valid || o_rsp.ready;

    vrq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .i_region_size (r_region_size),
        .i_slot_free   (w_slot_free),
        .i_rd_data     (w_rd_data),
        .o_wr          (w_wr),
        .o_rd_en       (w_rd_en),
        .o_rd_addr     (w_rd_addr),
        .o_done        (w_done),
        .o_result      (w_result)
    );

    vrq_hdr_mem u_hdr_mem (
        .i_clk     (i_clk),
        .i_wr      (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_size <= CAP_LEN;
        end else if (i_cfg_wr_en) begin
            r_region_size <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_done) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_rsp <= w_result;
        end
    end

    assign o_rsp.valid        = r_rsp_valid;
    assign o_rsp.status       = r_rsp.status;
    assign o_rsp.offset       = r_rsp.offset;
    assign o_rsp.length_out   = r_rsp.len;
    assign o_rsp.type_out     = r_rsp.typ;
    assign o_rsp.record_count = r_rsp.count;

endmodule

`default_nettype wire

[verif/tb_variable_record_ring_queue_core.sv]
`default_nettype none

module tb_variable_record_ring_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vrq_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;

    class ring_queue_scoreboard;
        logic [LEN_W-1:0] region_size;
        int unsigned      write_pos;
        int unsigned      read_pos;
        int unsigned      held_records;
        t_hdr             headers [CAPACITY];
        t_result          awaited_results [$];
        int unsigned      mismatches;
        int unsigned      status_tally [4];

        function new();
            region_size  = CAP_LEN;
            write_pos    = START_OFFSET;
            read_pos     = START_OFFSET;
            held_records = 0;
            mismatches   = 0;
            foreach (headers[i]) headers[i] = '0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        function void set_region(logic [LEN_W-1:0] value);
            region_size = value;
        endfunction

        function int unsigned ring_bytes();
            if (region_size > CAP_LEN) return CAPACITY;
            return region_size;
        endfunction

        function t_hdr header_at(int unsigned off);
            if (off < CAPACITY) return headers[off];
            return '0;
        endfunction

        function void put_header(int unsigned off, t_hdr value);
            if (off < CAPACITY) headers[off] = value;
        endfunction

        // skips pad headers and a tail too short for a header, wrapping once
        function bit find_oldest(output t_hdr found);
            int unsigned limit;
            limit = ring_bytes();
            found = '0;
            for (int pass = 0; pass < 2; pass++) begin
                if (write_pos > read_pos) begin
                    if (write_pos < read_pos + HEADER_SIZE) return 1'b0;
                    found = header_at(read_pos);
                    return 1'b1;
                end
                if (write_pos == read_pos) return 1'b0;
                if (read_pos + HEADER_SIZE <= limit) begin
                    found = header_at(read_pos);
                    if (!found.pad) return 1'b1;
                end
                if (pass == 1) return 1'b0;
                read_pos = START_OFFSET;
            end
            return 1'b0;
        endfunction

        function void note_request(t_op op, logic [LEN_W-1:0] len, logic [7:0] typ);
            t_result     want;
            t_hdr        hdr;
            int unsigned limit;
            bit          wrapped;
            bit          settled;
            want        = '0;
            want.status = ST_OK;
            case (op)
                OP_PUSH: begin
                    if (len < HDR_LEN) begin
                        want.status = ST_BAD_LEN;
                    end else begin
                        limit   = ring_bytes();
                        wrapped = 1'b0;
                        settled = 1'b0;
                        while (!settled) begin
                            if (write_pos >= read_pos && write_pos + len >= limit) begin
                                if (write_pos + HEADER_SIZE <= limit) begin
                                    hdr.pad = 1'b1;
                                    hdr.typ = '0;
                                    hdr.len = LEN_W'(limit - write_pos);
                                    put_header(write_pos, hdr);
                                end
                                if (read_pos == START_OFFSET || wrapped) begin
                                    want.status = ST_FULL;
                                    settled     = 1'b1;
                                end else begin
                                    write_pos = START_OFFSET;
                                    wrapped   = 1'b1;
                                end
                            end else if (write_pos < read_pos && write_pos + len >= read_pos) begin
                                want.status = ST_FULL;
                                settled     = 1'b1;
                            end else begin
                                hdr.pad = 1'b0;
                                hdr.typ = typ;
                                hdr.len = len;
                                put_header(write_pos, hdr);
                                want.offset = ADDR_W'(write_pos);
                                write_pos   = write_pos + len;
                                if (held_records < CNT_MAX) held_records++;
                                settled = 1'b1;
                            end
                        end
                    end
                end
                OP_PEEK, OP_POP: begin
                    if (find_oldest(hdr)) begin
                        want.offset = ADDR_W'(read_pos);
                        want.len    = hdr.len;
                        want.typ    = hdr.typ;
                        if (op == OP_POP) begin
                            if (read_pos + hdr.len > CAPACITY) read_pos = CAPACITY;
                            else read_pos = read_pos + hdr.len;
                            if (held_records > 0) held_records--;
                        end
                    end else begin
                        want.status = ST_EMPTY;
                    end
                end
                default: ;
            endcase
            want.count = CNT_W'(held_records);
            awaited_results.push_back(want);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_response(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                $error("response with no transaction outstanding");
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            status_tally[int'(want.status)]++;
            compare_field("status", want.status, got.status);
            compare_field("offset", want.offset, got.offset);
            compare_field("length_out", want.len, got.len);
            compare_field("type_out", want.typ, got.typ);
            compare_field("record_count", want.count, got.count);
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [LEN_W-1:0] i_cfg_wr_data;

    vrq_req_if req_if ();
    vrq_rsp_if rsp_if ();

    ring_queue_scoreboard queue_tracker;
    bit                   gaps_on;
    bit                   stalls_on;
    int unsigned          stall_left;
    int unsigned          quiet_cycles;
    int unsigned          sizes_tried;
    int unsigned          requests_sent;
    t_result              rsp_seen;

    variable_record_ring_queue_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if),
        .o_rsp         (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 4);
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_if.valid && rsp_if.ready) begin
                rsp_seen.status = t_status'(rsp_if.status);
                rsp_seen.offset = rsp_if.offset;
                rsp_seen.len    = rsp_if.length_out;
                rsp_seen.typ    = rsp_if.type_out;
                rsp_seen.count  = rsp_if.record_count;
                queue_tracker.check_response(rsp_seen);
            end
            if (req_if.valid && req_if.ready)
                queue_tracker.note_request(t_op'(req_if.operation), req_if.record_length,
                                           req_if.record_type);
            if (i_cfg_wr_en)
                queue_tracker.set_region(i_cfg_wr_data);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (req_if.valid && req_if.ready)
                || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet_cycles);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(t_op op, int unsigned len, int unsigned typ);
        if (gaps_on && $urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        @(negedge i_clk);
        req_if.valid         <= 1'b1;
        req_if.operation     <= op;
        req_if.record_length <= LEN_W'(len);
        req_if.record_type   <= 8'(typ);
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        requests_sent++;
    endtask

    task automatic await_results();
        int unsigned guard;
        guard = 0;
        @(negedge i_clk);
        while (queue_tracker.awaited_results.size() != 0 && guard < QUIET_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic drain_queue();
        int unsigned guard;
        guard = 0;
        @(negedge i_clk);
        while (queue_tracker.held_records != 0 && guard < 1000) begin
            send(OP_POP, 0, 0);
            guard++;
        end
    endtask

    task automatic directed_checks();
        send(OP_POP, 0, 0);
        send(OP_PEEK, 0, 0);
        send(OP_NOP, 4095, 255);
        send(OP_PUSH, 0, 0);
        send(OP_PUSH, HEADER_SIZE - 1, 255);
        send(OP_PUSH, CAPACITY, 255);
        send(OP_PUSH, HEADER_SIZE, 0);
        send(OP_PUSH, CAPACITY - 1, 255);
        send(OP_PUSH, 1365, 8'hAA);
        send(OP_PUSH, 2730, 8'h55);
        send(OP_PEEK, 0, 0);
        send(OP_POP, 0, 0);
        send(OP_POP, 0, 0);
        send(OP_PUSH, 2700, 1);
        send(OP_PUSH, 100, 2);
        send(OP_PEEK, 0, 0);
        send(OP_POP, 0, 0);
        send(OP_PEEK, 0, 0);
        send(OP_PUSH, 4000, 3);
        send(OP_POP, 0, 0);
        send(OP_POP, 0, 0);
        send(OP_PUSH, 3900, 4);
        send(OP_PUSH, 200, 5);
        send(OP_PUSH, 50, 6);
        send(OP_POP, 0, 0);
        send(OP_PEEK, 0, 0);
    endtask

    task automatic run_phase(int unsigned sz, int unsigned n_items);
        int unsigned span;
        int unsigned pick;
        int unsigned len;
        span = (sz > CAPACITY) ? CAPACITY : ((sz < 2 * HEADER_SIZE) ? 2 * HEADER_SIZE : sz);
        drain_queue();
        await_results();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= LEN_W'(sz);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sizes_tried++;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 48) begin
                case ($urandom_range(0, 19))
                    0:       len = $urandom_range(0, HEADER_SIZE - 1);
                    1:       len = $urandom_range(0, CAPACITY);
                    2, 3:    len = $urandom_range(HEADER_SIZE, span);
                    default: len = $urandom_range(HEADER_SIZE, HEADER_SIZE + span / 6);
                endcase
                send(OP_PUSH, len, $urandom_range(0, 255));
            end else if (pick < 80) begin
                send(OP_POP, $urandom_range(0, CAPACITY), $urandom_range(0, 255));
            end else if (pick < 96) begin
                send(OP_PEEK, $urandom_range(0, CAPACITY), $urandom_range(0, 255));
            end else begin
                send(OP_NOP, $urandom_range(0, CAPACITY), $urandom_range(0, 255));
            end
        end
    endtask

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_wr_en          = 1'b0;
        i_cfg_wr_data        = '0;
        req_if.valid         = 1'b0;
        req_if.operation     = '0;
        req_if.record_length = '0;
        req_if.record_type   = '0;
        rsp_if.ready         = 1'b0;
        gaps_on              = 1'b1;
        stalls_on            = 1'b1;
        stall_left           = 0;
        quiet_cycles         = 0;
        sizes_tried          = 0;
        requests_sent        = 0;
        queue_tracker        = new();

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();
        run_phase(512, 90);
        run_phase(8191, 90);
        run_phase(64, 90);
        run_phase(0, 30);
        run_phase(25, 40);
        run_phase(4095, 90);
        run_phase(1000, 90);
        drain_queue();
        await_results();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_phase(CAPACITY, 90);
        await_results();

        if (queue_tracker.awaited_results.size() != 0) begin
            $error("%0d expected responses never arrived",
                   queue_tracker.awaited_results.size());
            queue_tracker.mismatches++;
        end
        $display("covered %0d requests over %0d region sizes, incl. wrap, pad skip and full",
                 requests_sent, sizes_tried);
        $display("responses: %0d ok, %0d full, %0d empty, %0d bad length",
                 queue_tracker.status_tally[0], queue_tracker.status_tally[1],
                 queue_tracker.status_tally[2], queue_tracker.status_tally[3]);
        if (queue_tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire
